// ----- hw/rtl/okd_pkg.sv -----
// Shared constants, types and elaboration-time tables for the OKLab distance pipeline.
// Holds the sRGB linearization ROM, the two OKLab matrices and the cube-root seed table.
// No dependencies.
package okd_pkg;

    localparam int INTERNAL_FRAC_BITS = 20;
    localparam int FRAC   = INTERNAL_FRAC_BITS;

    localparam int CH     = 3;                  // channels per color
    localparam int LANES  = 2 * CH;             // two colors side by side
    localparam int ROM_W  = 31;                 // Q0.30 entry, 1.0 included

    localparam int XW     = FRAC + 1;           // LMS value before cube root
    localparam int YW     = FRAC + 2;           // Newton estimate
    localparam int QW     = FRAC + 2;           // quotient bits per division
    localparam int RW     = 2 * FRAC + 2;       // dividend / partial remainder
    localparam int NW     = FRAC + 4;           // 2y + t2
    localparam int KW     = NW + 2;             // reciprocal-of-3 scale
    localparam int PW     = NW + KW;            // product for the divide by 3
    localparam int SSW    = $clog2(YW);

    localparam int NEWTON_STEPS = 6;
    localparam int STEP_STG     = 2 * QW + 1;   // two long divisions and one multiply
    localparam int CBRT_STG     = NEWTON_STEPS * STEP_STG;

    localparam int CW     = 33;                 // signed Lab coefficient
    localparam int LW     = FRAC + 5;           // signed Lab value

    localparam logic [KW-1:0] DIV3_MUL = KW'(((longint'(1) << KW) + 2) / 3);

    typedef logic [ROM_W-1:0]        t_rom      [256];
    typedef logic [SSW-1:0]          t_seed_tab [XW];
    typedef logic [29:0]             t_lms_mat  [CH][CH];
    typedef logic signed [CW-1:0]    t_lab_mat  [CH][CH];
    typedef logic [XW-1:0]           t_x_vec    [LANES];
    typedef logic [YW-1:0]           t_y_vec    [LANES];

    localparam t_lms_mat LMS_MAT = '{
        '{30'd442619433, 30'd575882691, 30'd55239717},
        '{30'd227529651, 30'd730895523, 30'd115316608},
        '{30'd94814044,  30'd302493301, 30'd676434478}
    };

    localparam t_lab_mat LAB_MAT = '{
        '{33'sd225973541,  33'sd852140624,   -33'sd4372327},
        '{33'sd2123859717, -33'sd2607681019, 33'sd483821301},
        '{33'sd27814248,   33'sd840494788,   -33'sd868308995}
    };

    function automatic longint unsigned f_pow5(input longint unsigned y);
        longint unsigned p;
        p = y;
        for (int i = 0; i < 4; i++) begin
            p = (p * y) >> 30;
        end
        return p;
    endfunction

    // sRGB decode curve; the power segment is t^2.4 = t^2 * t^(2/5)
    function automatic t_rom f_build_rom();
        t_rom            rom;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned r;
        longint unsigned cand;
        for (int v = 0; v < 256; v++) begin
            if (v <= 10) begin
                rom[v] = ROM_W'(((longint'(v) * 100 << 30) + 164730) / 329460);
            end else begin
                t  = (((longint'(v) * 1000 + 14025) << 30) + 134512) / 269025;
                t2 = (t * t + (longint'(1) << 29)) >> 30;
                r  = 0;
                for (int b = 30; b >= 0; b--) begin
                    cand = r | (longint'(1) << b);
                    if (cand <= (longint'(1) << 30) && f_pow5(cand) <= t2) begin
                        r = cand;
                    end
                end
                rom[v] = ROM_W'((t2 * r + (longint'(1) << 29)) >> 30);
            end
        end
        return rom;
    endfunction

    localparam t_rom LIN_ROM = f_build_rom();

    // seed exponent per leading-one position of the cube-root input
    function automatic t_seed_tab f_seed_tab();
        t_seed_tab tab;
        for (int p = 0; p < XW; p++) begin
            tab[p] = SSW'(FRAC + (p - FRAC + 33) / 3 - 10);
        end
        return tab;
    endfunction

    localparam t_seed_tab SEED_SH = f_seed_tab();

endpackage

// ----- hw/rtl/okd_cbrt.sv -----
// Six-lane pipelined Newton cube root in Q FRAC, fixed step count.
// Each step: two restoring divisions (one quotient bit per stage) and a divide by 3.
// Depends on okd_pkg.
module okd_cbrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  okd_pkg::t_x_vec i_x,
    output logic            o_valid,
    output okd_pkg::t_y_vec o_y
);
    import okd_pkg::*;

    typedef struct packed {
        logic          zero;
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic [RW-1:0] rem;
        logic [QW-1:0] q;
        logic [PW-1:0] prod;
    } t_nw_st;

    function automatic t_nw_st f_seed(input logic [XW-1:0] x);
        t_nw_st         st;
        logic [SSW-1:0] sh;
        st      = '0;
        st.x    = x;
        st.zero = (x == '0);
        sh      = SEED_SH[0];
        for (int p = 0; p < XW; p++) begin
            if (x[p]) begin
                sh = SEED_SH[p];
            end
        end
        st.y = YW'(1) << sh;
        return st;
    endfunction

    // k: stage within the step; first: step 0 takes y from the seed, later from the product
    function automatic t_nw_st f_stage(input t_nw_st src, input int k, input logic first);
        t_nw_st        st;
        logic [YW-1:0] yin;
        logic [RW+1:0] dvs;
        logic [NW-1:0] v;
        int            bi;
        st = src;
        if (k == 0) begin
            yin    = first ? src.y : src.prod[KW +: YW];
            st.y   = (yin == '0) ? YW'(1) : yin;
            st.rem = RW'({st.x, {FRAC{1'b0}}});
            st.q   = '0;
        end else if (k == QW) begin
            st.rem = {st.q, {FRAC{1'b0}}};
            st.q   = '0;
        end
        if (k < 2 * QW) begin
            bi  = (k < QW) ? (QW - 1 - k) : (2 * QW - 1 - k);
            dvs = (RW + 2)'(st.y) << bi;
            if ({2'b00, st.rem} >= dvs) begin
                st.rem = st.rem - dvs[RW-1:0];
                st.q   = st.q | (QW'(1) << bi);
            end
        end else begin
            v       = NW'({st.y, 1'b0}) + NW'(st.q);
            st.prod = PW'(v) * PW'(DIV3_MUL);
        end
        return st;
    endfunction

    t_nw_st            r_pre [LANES];
    t_nw_st            n_pre [LANES];
    t_nw_st            r_st  [CBRT_STG][LANES];
    t_nw_st            n_st  [CBRT_STG][LANES];
    logic [CBRT_STG:0] r_v;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign n_pre[l] = f_seed(i_x[l]);
        for (genvar g = 0; g < CBRT_STG; g++) begin : g_stg
            if (g == 0) begin : g_first
                assign n_st[g][l] = f_stage(r_pre[l], 0, 1'b1);
            end else begin : g_next
                assign n_st[g][l] = f_stage(r_st[g-1][l], g % STEP_STG, 1'b0);
            end
        end
        assign o_y[l] = r_st[CBRT_STG-1][l].zero ? '0 :
                        r_st[CBRT_STG-1][l].prod[KW +: YW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[CBRT_STG-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pre <= n_pre;
            r_st  <= n_st;
        end
    end

    assign o_valid = r_v[CBRT_STG];

endmodule

// ----- hw/rtl/oklab_color_distance_top.sv -----
// Top level: stream wrapper and pipeline for the squared OKLab distance of two sRGB colors.
// Uses okd_pkg for tables and widths, okd_cbrt for the cube roots.
//
// Takes one color pair per clock while the skid stage is empty and returns one distance
// per pair, in order. The cube root runs six Newton steps, each built from two long
// divisions at one quotient bit per stage plus a multiply for the divide by three.
// Output register plus a skid stage: tready depends only on the skid being empty.
module oklab_color_distance_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // color_a [23:0], color_b [47:24]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // distance [31:0]
);
    import okd_pkg::*;

    localparam int LPW   = 30 + XW;
    localparam int BPW   = CW + YW + 1;
    localparam int BSW   = BPW + 2;
    localparam int SQW   = 2 * LW + 2;
    localparam int SSUMW = SQW + 2;
    localparam int EXW   = SSUMW + 6;
    localparam int OSH   = 2 * FRAC - 30;

    logic        adv;
    logic [7:0]  r_v;
    logic [23:0] r_col_a;
    logic [23:0] r_col_b;

    logic [7:0]             w_ch   [LANES];
    logic [ROM_W:0]         w_rsum [LANES];
    t_x_vec                 r_rgb;
    t_x_vec                 n_rgb;
    logic [LPW-1:0]         r_lp   [LANES][CH];
    logic [LPW-1:0]         n_lp   [LANES][CH];
    logic [LPW+1:0]         w_lsum [LANES];
    t_x_vec                 r_lms;
    t_x_vec                 n_lms;
    logic                   w_cb_valid;
    t_y_vec                 w_y;
    logic signed [BPW-1:0]  r_bp   [LANES][CH];
    logic signed [BPW-1:0]  n_bp   [LANES][CH];
    logic signed [BSW-1:0]  w_bsum [LANES];
    logic signed [LW-1:0]   r_lab  [LANES];
    logic signed [LW-1:0]   n_lab  [LANES];
    logic signed [LW:0]     w_d    [CH];
    logic [LW:0]            r_dif  [CH];
    logic [LW:0]            n_dif  [CH];
    logic [SQW-1:0]         r_sq   [CH];
    logic [SQW-1:0]         n_sq   [CH];
    logic [SSUMW-1:0]       w_ssum;
    logic [EXW-1:0]         w_q30;
    logic [31:0]            n_dist;

    logic        r_out_valid;
    logic [31:0] r_out_dist;
    logic        r_skid_valid;
    logic [31:0] r_skid_dist;
    logic        leave;

    assign adv             = !r_skid_valid;
    assign o_s_axis_tready = adv;

    for (genvar c = 0; c < 2; c++) begin : g_col
        for (genvar i = 0; i < CH; i++) begin : g_ch
            assign w_ch[c*CH+i]   = (c == 0) ? r_col_a[16-8*i +: 8] : r_col_b[16-8*i +: 8];
            assign w_rsum[c*CH+i] = {1'b0, LIN_ROM[w_ch[c*CH+i]]}
                                    + ((ROM_W + 1)'(1) << (29 - FRAC));
            assign n_rgb[c*CH+i]  = w_rsum[c*CH+i][30-FRAC +: XW];

            for (genvar j = 0; j < CH; j++) begin : g_mac
                assign n_lp[c*CH+i][j] = LPW'(LMS_MAT[i][j]) * LPW'(r_rgb[c*CH+j]);
                assign n_bp[c*CH+i][j] = BPW'(LAB_MAT[i][j]) * $signed(BPW'(w_y[c*CH+j]));
            end

            assign w_lsum[c*CH+i] = (LPW + 2)'(r_lp[c*CH+i][0]) + (LPW + 2)'(r_lp[c*CH+i][1])
                                    + (LPW + 2)'(r_lp[c*CH+i][2]) + ((LPW + 2)'(1) << 29);
            assign n_lms[c*CH+i]  = w_lsum[c*CH+i][30 +: XW];

            // two's complement slice is the floor shift
            assign w_bsum[c*CH+i] = BSW'(r_bp[c*CH+i][0]) + BSW'(r_bp[c*CH+i][1])
                                    + BSW'(r_bp[c*CH+i][2]) + (BSW'(1) <<< 29);
            assign n_lab[c*CH+i]  = w_bsum[c*CH+i][30 +: LW];
        end
    end

    for (genvar i = 0; i < CH; i++) begin : g_diff
        assign w_d[i]   = {r_lab[i][LW-1], r_lab[i]} - {r_lab[CH+i][LW-1], r_lab[CH+i]};
        assign n_dif[i] = w_d[i][LW] ? (LW + 1)'(-w_d[i]) : (LW + 1)'(w_d[i]);
        assign n_sq[i]  = SQW'(r_dif[i]) * SQW'(r_dif[i]);
    end

    assign w_ssum = SSUMW'(r_sq[0]) + SSUMW'(r_sq[1]) + SSUMW'(r_sq[2]);

    if (OSH > 0) begin : g_rnd_down
        assign w_q30 = EXW'((w_ssum + (SSUMW'(1) << (OSH - 1))) >> OSH);
    end else if (OSH < 0) begin : g_rnd_up
        assign w_q30 = EXW'(w_ssum) << (-OSH);
    end else begin : g_rnd_none
        assign w_q30 = EXW'(w_ssum);
    end

    assign n_dist = (w_q30 > EXW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : w_q30[31:0];

    okd_cbrt u_cbrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_v[3]),
        .i_x     (r_lms),
        .o_valid (w_cb_valid),
        .o_y     (w_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[6:4], w_cb_valid, r_v[2:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_col_a <= i_s_axis_tdata[23:0];
            r_col_b <= i_s_axis_tdata[47:24];
            r_rgb   <= n_rgb;
            r_lp    <= n_lp;
            r_lms   <= n_lms;
            r_bp    <= n_bp;
            r_lab   <= n_lab;
            r_dif   <= n_dif;
            r_sq    <= n_sq;
        end
    end

    // a finished item moves to the output register, or parks in the skid when that is held
    assign leave = adv && r_v[7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_axis_tready) begin
            r_out_valid  <= r_skid_valid || leave;
            r_skid_valid <= 1'b0;
        end else if (leave) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_axis_tready) begin
            r_out_dist <= r_skid_valid ? r_skid_dist : n_dist;
        end else if (leave) begin
            r_skid_dist <= n_dist;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_dist;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds data while output register is empty");

    a_skid_catch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (leave && r_out_valid && !i_m_axis_tready) |=> (r_skid_valid && r_out_valid))
        else $error("finished transfer dropped at stalled output");

    a_same_lab_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_v[5] && r_lab[0] == r_lab[3] && r_lab[1] == r_lab[4]
         && r_lab[2] == r_lab[5]) |=> (r_dif[0] == '0 && r_dif[1] == '0 && r_dif[2] == '0))
        else $error("equal Lab triples give nonzero difference");

endmodule
